// ===== rtl/swt_pkg.sv =====
// shared types and constants for the stopwatch with time readout
// no dependencies; used by swt_split, stopwatch_with_time_readout, swt_readout_checker and the testbench

package swt_pkg;

    localparam int unsigned TIME_W   = 40;
    localparam int unsigned MODE_W   = 2;
    localparam int unsigned HOURS_W  = 19;
    localparam int unsigned MIN_W    = 6;
    localparam int unsigned SEC_W    = 6;
    localparam int unsigned TENTHS_W = 4;

    // stream payload widths, padded to whole bytes
    localparam int unsigned IN_TDATA_W  = ((TIME_W + 7) / 8) * 8;
    localparam int unsigned OUT_FIELD_W = MODE_W + TIME_W + HOURS_W + MIN_W + SEC_W + TENTHS_W;
    localparam int unsigned OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;
    localparam int unsigned OUT_PAD_W   = OUT_TDATA_W - OUT_FIELD_W;

    // operation codes carried in tuser
    localparam logic OP_PRESS = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef enum logic [MODE_W-1:0] {
        MODE_READY   = 2'd0,
        MODE_RUNNING = 2'd1,
        MODE_STOPPED = 2'd2
    } t_mode;

    localparam logic [TIME_W-1:0] MS_PER_HOUR  = 40'd3600000;
    localparam logic [9:0]        MS_PER_SEC   = 10'd1000;
    localparam logic [6:0]        PER_SIXTY    = 7'd60;
    localparam logic [7:0]        MS_PER_TENTH = 8'd100;

    // floor reciprocals 2^s / d, with s the bit width of the dividend
    localparam logic [10:0] RCP_SEC_HI = 11'((64'd1 << 20) / 64'd1000);
    localparam logic [20:0] RCP_SEC_LO = 21'((64'd1 << 30) / 64'd1000);
    localparam logic [25:0] RCP_MIN    = 26'((64'd1 << 31) / 64'd60);
    localparam logic [19:0] RCP_HOUR   = 20'((64'd1 << 25) / 64'd60);
    localparam logic [3:0]  RCP_TENTH  = 4'((64'd1 << 10) / 64'd100);

    // state and elapsed time after one transfer, handed to the split pipeline
    typedef struct packed {
        t_mode             mode;
        logic [TIME_W-1:0] elapsed;
    } t_swt_item;

    typedef struct packed {
        t_mode               mode;
        logic [TIME_W-1:0]   elapsed;
        logic                long_form;
        logic [HOURS_W-1:0]  hours;
        logic [MIN_W-1:0]    minutes;
        logic [SEC_W-1:0]    seconds;
        logic [TENTHS_W-1:0] tenths;
    } t_swt_result;

endpackage

// ===== rtl/swt_split.sv =====
// pipelined split of elapsed milliseconds into hours, minutes, seconds, tenths
// depends on swt_pkg; reciprocal multiply then one-step correction per divide

module swt_split (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  swt_pkg::t_swt_item   i_item,
    output logic                 o_valid,
    input  logic                 i_ready,
    output swt_pkg::t_swt_result o_result
);

    typedef struct packed {
        swt_pkg::t_mode               mode;
        logic [swt_pkg::TIME_W-1:0]   elapsed;
        logic                         long_form;
    } t_tag;

    localparam int unsigned NSTG = 9;

    logic [NSTG:1]   r_vld;
    logic [NSTG:1]   n_vld;
    logic [NSTG+1:1] en;

    // stage enables: a stage loads when empty or when its content moves on
    always_comb begin
        en[NSTG+1] = i_ready;
        for (int k = NSTG; k >= 1; k--) begin
            en[k] = !r_vld[k] || en[k+1];
        end
    end

    assign n_vld   = {r_vld[NSTG-1:1], i_valid};
    assign o_ready = en[1];
    assign o_valid = r_vld[NSTG];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            for (int k = 1; k <= NSTG; k++) begin
                if (en[k]) begin
                    r_vld[k] <= n_vld[k];
                end
            end
        end
    end

    // stage 1: capture
    swt_pkg::t_swt_item r1_item;

    // stage 2: estimate of the high half over 1000
    t_tag        r2_tag, n2_tag;
    logic [10:0] r2_qh0, n2_qh0;
    logic [30:0] s2_prod;

    assign s2_prod = 31'(r1_item.elapsed[39:20]) * 31'(swt_pkg::RCP_SEC_HI);
    always_comb begin
        n2_tag.mode      = r1_item.mode;
        n2_tag.elapsed   = r1_item.elapsed;
        n2_tag.long_form = (r1_item.elapsed >= swt_pkg::MS_PER_HOUR);
        n2_qh0           = s2_prod[30:20];
    end

    // stage 3: correct the high quotient
    t_tag        r3_tag;
    logic [10:0] r3_qh, n3_qh;
    logic [9:0]  r3_rh, n3_rh;
    logic [20:0] s3_prod;
    logic [20:0] s3_diff;

    assign s3_prod = 21'(r2_qh0) * 21'(swt_pkg::MS_PER_SEC);
    assign s3_diff = {1'b0, r2_tag.elapsed[39:20]} - s3_prod;
    always_comb begin
        if (s3_diff[10:0] >= 11'(swt_pkg::MS_PER_SEC)) begin
            n3_qh = r2_qh0 + 11'd1;
            n3_rh = 10'(s3_diff[10:0] - 11'(swt_pkg::MS_PER_SEC));
        end else begin
            n3_qh = r2_qh0;
            n3_rh = s3_diff[9:0];
        end
    end

    // stage 4: estimate of the low part over 1000
    t_tag        r4_tag;
    logic [10:0] r4_qh;
    logic [29:0] r4_y, n4_y;
    logic [19:0] r4_ql0, n4_ql0;
    logic [50:0] s4_prod;

    assign n4_y    = {r3_rh, r3_tag.elapsed[19:0]};
    assign s4_prod = 51'(n4_y) * 51'(swt_pkg::RCP_SEC_LO);
    assign n4_ql0  = s4_prod[49:30];

    // stage 5: correct, giving whole seconds and the millisecond rest
    t_tag        r5_tag;
    logic [30:0] r5_sec_all, n5_sec_all;
    logic [9:0]  r5_ms, n5_ms;
    logic [29:0] s5_prod;
    logic [29:0] s5_diff;

    assign s5_prod = 30'(r4_ql0) * 30'(swt_pkg::MS_PER_SEC);
    assign s5_diff = r4_y - s5_prod;
    always_comb begin
        if (s5_diff[10:0] >= 11'(swt_pkg::MS_PER_SEC)) begin
            n5_sec_all = {r4_qh, r4_ql0 + 20'd1};
            n5_ms      = 10'(s5_diff[10:0] - 11'(swt_pkg::MS_PER_SEC));
        end else begin
            n5_sec_all = {r4_qh, r4_ql0};
            n5_ms      = s5_diff[9:0];
        end
    end

    // stage 6: estimates of seconds over 60 and milliseconds over 100
    t_tag        r6_tag;
    logic [30:0] r6_sec_all;
    logic [9:0]  r6_ms;
    logic [24:0] r6_mq0, n6_mq0;
    logic [3:0]  r6_t0, n6_t0;
    logic [56:0] s6_prod;
    logic [13:0] s6_tprod;

    assign s6_prod  = 57'(r5_sec_all) * 57'(swt_pkg::RCP_MIN);
    assign s6_tprod = 14'(r5_ms) * 14'(swt_pkg::RCP_TENTH);
    assign n6_mq0   = s6_prod[55:31];
    assign n6_t0    = s6_tprod[13:10];

    // stage 7: correct seconds and tenths
    t_tag        r7_tag;
    logic [24:0] r7_min_all, n7_min_all;
    logic [5:0]  r7_sec, n7_sec;
    logic [3:0]  r7_tenths, n7_tenths;
    logic [30:0] s7_prod;
    logic [30:0] s7_diff;
    logic [9:0]  s7_tprod;
    logic [9:0]  s7_tdiff;

    assign s7_prod  = 31'(r6_mq0) * 31'(swt_pkg::PER_SIXTY);
    assign s7_diff  = r6_sec_all - s7_prod;
    assign s7_tprod = 10'(r6_t0) * 10'(swt_pkg::MS_PER_TENTH);
    assign s7_tdiff = r6_ms - s7_tprod;
    always_comb begin
        if (s7_diff[6:0] >= swt_pkg::PER_SIXTY) begin
            n7_min_all = r6_mq0 + 25'd1;
            n7_sec     = 6'(s7_diff[6:0] - swt_pkg::PER_SIXTY);
        end else begin
            n7_min_all = r6_mq0;
            n7_sec     = s7_diff[5:0];
        end
        if (s7_tdiff[7:0] >= swt_pkg::MS_PER_TENTH) begin
            n7_tenths = r6_t0 + 4'd1;
        end else begin
            n7_tenths = r6_t0;
        end
    end

    // stage 8: estimate of minutes over 60
    t_tag        r8_tag;
    logic [24:0] r8_min_all;
    logic [5:0]  r8_sec;
    logic [3:0]  r8_tenths;
    logic [18:0] r8_hq0, n8_hq0;
    logic [44:0] s8_prod;

    assign s8_prod = 45'(r7_min_all) * 45'(swt_pkg::RCP_HOUR);
    assign n8_hq0  = s8_prod[43:25];

    // stage 9: correct hours and minutes, result register
    t_tag        r9_tag;
    logic [18:0] r9_hours, n9_hours;
    logic [5:0]  r9_min, n9_min;
    logic [5:0]  r9_sec;
    logic [3:0]  r9_tenths;
    logic [24:0] s9_prod;
    logic [24:0] s9_diff;

    assign s9_prod = 25'(r8_hq0) * 25'(swt_pkg::PER_SIXTY);
    assign s9_diff = r8_min_all - s9_prod;
    always_comb begin
        if (s9_diff[6:0] >= swt_pkg::PER_SIXTY) begin
            n9_hours = r8_hq0 + 19'd1;
            n9_min   = 6'(s9_diff[6:0] - swt_pkg::PER_SIXTY);
        end else begin
            n9_hours = r8_hq0;
            n9_min   = s9_diff[5:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[1]) begin
            r1_item <= i_item;
        end
        if (en[2]) begin
            r2_tag <= n2_tag;
            r2_qh0 <= n2_qh0;
        end
        if (en[3]) begin
            r3_tag <= r2_tag;
            r3_qh  <= n3_qh;
            r3_rh  <= n3_rh;
        end
        if (en[4]) begin
            r4_tag <= r3_tag;
            r4_qh  <= r3_qh;
            r4_y   <= n4_y;
            r4_ql0 <= n4_ql0;
        end
        if (en[5]) begin
            r5_tag     <= r4_tag;
            r5_sec_all <= n5_sec_all;
            r5_ms      <= n5_ms;
        end
        if (en[6]) begin
            r6_tag     <= r5_tag;
            r6_sec_all <= r5_sec_all;
            r6_ms      <= r5_ms;
            r6_mq0     <= n6_mq0;
            r6_t0      <= n6_t0;
        end
        if (en[7]) begin
            r7_tag     <= r6_tag;
            r7_min_all <= n7_min_all;
            r7_sec     <= n7_sec;
            r7_tenths  <= n7_tenths;
        end
        if (en[8]) begin
            r8_tag     <= r7_tag;
            r8_min_all <= r7_min_all;
            r8_sec     <= r7_sec;
            r8_tenths  <= r7_tenths;
            r8_hq0     <= n8_hq0;
        end
        if (en[9]) begin
            r9_tag    <= r8_tag;
            r9_hours  <= n9_hours;
            r9_min    <= n9_min;
            r9_sec    <= r8_sec;
            r9_tenths <= r8_tenths;
        end
    end

    // long form shows hours and drops tenths
    always_comb begin
        o_result.mode      = r9_tag.mode;
        o_result.elapsed   = r9_tag.elapsed;
        o_result.long_form = r9_tag.long_form;
        o_result.hours     = r9_tag.long_form ? r9_hours : '0;
        o_result.minutes   = r9_min;
        o_result.seconds   = r9_sec;
        o_result.tenths    = r9_tag.long_form ? '0 : r9_tenths;
    end

endmodule

// ===== rtl/stopwatch_with_time_readout.sv =====
// top level of the stopwatch with time readout: mode control and stream ports
// depends on swt_pkg and swt_split

// Three-state stopwatch (ready, running, stopped) fed with timestamped transfers.
// Each input transfer carries a 40-bit millisecond time in tdata and the
// operation in tuser (0 press, 1 query). A press steps ready -> running
// (start time taken), running -> stopped (elapsed time held) and stopped ->
// ready (all cleared); a query changes nothing. Every input transfer yields
// exactly one output transfer with the mode after the transfer, the elapsed
// milliseconds (zero if time ran backwards while running) and the readout
// split into hours, minutes, seconds and tenths; tuser flags the long form
// (one hour or more: hours valid, tenths zero). The block takes one transfer
// per clock unless back pressure has filled the pipeline; results leave in
// order through the chain of reciprocal-multiply and correction stages that
// divide by 1000, 60, 60 and 100. Back pressure stalls only the stages that
// hold data, so bubbles are absorbed before the input is held off.

module stopwatch_with_time_readout (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // slave side
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    input  logic [swt_pkg::IN_TDATA_W-1:0]    i_s_tdata,   // [39:0] now_ms
    input  logic                              i_s_tuser,   // [0] op
    // master side
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    // [1:0] watch_mode, [41:2] elapsed_ms, [60:42] hours, [66:61] minutes,
    // [72:67] seconds, [76:73] tenths, [79:77] zero
    output logic [swt_pkg::OUT_TDATA_W-1:0]   o_m_tdata,
    output logic                              o_m_tuser    // [0] long_form
);

    swt_pkg::t_mode               r_mode, n_mode;
    logic [swt_pkg::TIME_W-1:0]   r_start, n_start;
    logic [swt_pkg::TIME_W-1:0]   r_held, n_held;
    logic [swt_pkg::TIME_W-1:0]   now;
    logic [swt_pkg::TIME_W-1:0]   run_el;
    logic                         s_xfer;
    swt_pkg::t_swt_item           item;
    swt_pkg::t_swt_result         res;

    assign now    = i_s_tdata[swt_pkg::TIME_W-1:0];
    assign s_xfer = i_s_tvalid && o_s_tready;

    // running time against the stored start, clamped when the clock went back
    assign run_el = (now < r_start) ? '0 : (now - r_start);

    // next state
    always_comb begin
        n_mode  = r_mode;
        n_start = r_start;
        n_held  = r_held;
        if (i_s_tuser == swt_pkg::OP_PRESS) begin
            unique case (r_mode)
                swt_pkg::MODE_READY: begin
                    n_mode  = swt_pkg::MODE_RUNNING;
                    n_start = now;
                    n_held  = '0;
                end
                swt_pkg::MODE_RUNNING: begin
                    n_mode = swt_pkg::MODE_STOPPED;
                    n_held = run_el;
                end
                default: begin
                    // stopped or unused code: clear everything
                    n_mode  = swt_pkg::MODE_READY;
                    n_start = '0;
                    n_held  = '0;
                end
            endcase
        end
    end

    // outputs: elapsed time seen after the transfer
    always_comb begin
        item.mode = n_mode;
        if (n_mode == swt_pkg::MODE_RUNNING) begin
            // a press from ready starts at now, so elapsed reads zero
            item.elapsed = (r_mode == swt_pkg::MODE_RUNNING) ? run_el : '0;
        end else begin
            item.elapsed = n_held;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= swt_pkg::MODE_READY;
            r_start <= '0;
            r_held  <= '0;
        end else if (s_xfer) begin
            r_mode  <= n_mode;
            r_start <= n_start;
            r_held  <= n_held;
        end
    end

    swt_split u_split (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_s_tvalid),
        .o_ready  (o_s_tready),
        .i_item   (item),
        .o_valid  (o_m_tvalid),
        .i_ready  (i_m_tready),
        .o_result (res)
    );

    assign o_m_tdata = {{swt_pkg::OUT_PAD_W{1'b0}}, res.tenths, res.seconds, res.minutes,
                        res.hours, res.elapsed, res.mode};
    assign o_m_tuser = res.long_form;

    // a press from ready always lands in running
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_xfer && (i_s_tuser == swt_pkg::OP_PRESS) && (r_mode == swt_pkg::MODE_READY)
        |=> (r_mode == swt_pkg::MODE_RUNNING))
        else $error("press from ready did not start the watch");

    // a query leaves all state untouched
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_xfer && (i_s_tuser == swt_pkg::OP_QUERY)
        |=> $stable(r_mode) && $stable(r_start) && $stable(r_held))
        else $error("query changed stopwatch state");

    // corrected remainders stay in range
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (res.minutes < 6'd60) && (res.seconds < 6'd60) && (res.tenths < 4'd10))
        else $error("readout digit out of range");

    // long form carries hours and no tenths, short form the reverse
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (res.long_form ? (res.tenths == '0) : (res.hours == '0)))
        else $error("readout form mismatch");

endmodule

// ===== test/swt_readout_checker.sv =====
// checker for the stopwatch with time readout: predicts every readout and compares
// watches both stream channels of the block; depends on swt_pkg

module swt_readout_checker
    import swt_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_tvalid,
    input  logic                   i_s_tready,
    input  logic [IN_TDATA_W-1:0]  i_s_tdata,    // [39:0] now_ms
    input  logic                   i_s_tuser,    // [0] op
    input  logic                   i_m_tvalid,
    input  logic                   i_m_tready,
    // [1:0] watch_mode, [41:2] elapsed_ms, [60:42] hours, [66:61] minutes,
    // [72:67] seconds, [76:73] tenths, [79:77] zero
    input  logic [OUT_TDATA_W-1:0] i_m_tdata,
    input  logic                   i_m_tuser,    // [0] long_form
    output int                     o_fail_count,
    output int                     o_pending,
    output int                     o_checked,
    output int                     o_long_seen
);

    timeunit 1ns;
    timeprecision 1ps;

    localparam longint unsigned HOUR_MS   = 64'd3600000;
    localparam longint unsigned MINUTE_MS = 64'd60000;
    localparam longint unsigned SECOND_MS = 64'd1000;
    localparam longint unsigned TENTH_MS  = 64'd100;
    localparam int              MAX_LINES = 40;

    typedef struct {
        t_mode               mode;
        logic [TIME_W-1:0]   elapsed;
        logic                long_form;
        logic [HOURS_W-1:0]  hours;
        logic [MIN_W-1:0]    minutes;
        logic [SEC_W-1:0]    seconds;
        logic [TENTHS_W-1:0] tenths;
    } t_readout;

    // predicted stopwatch state
    t_mode             watch_mode = MODE_READY;
    logic [TIME_W-1:0] start_ms   = '0;
    logic [TIME_W-1:0] held_ms    = '0;

    t_readout readout_q[$];
    int       fail_count = 0;
    int       checked    = 0;
    int       long_seen  = 0;

    assign o_fail_count = fail_count;
    assign o_checked    = checked;
    assign o_long_seen  = long_seen;

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        fail_count++;
        if (fail_count <= MAX_LINES) begin
            $display("%0t: readout %0d %s: got 0x%0h, expected 0x%0h",
                     $time, checked, what, got, want);
        end
    endtask

    function automatic void clear_watch();
        watch_mode = MODE_READY;
        start_ms   = '0;
        held_ms    = '0;
    endfunction

    // held time unless running; running: time since start, zero when the clock went backwards
    function automatic logic [TIME_W-1:0] elapsed_at(input logic [TIME_W-1:0] now_ms);
        if (watch_mode != MODE_RUNNING) return held_ms;
        if (now_ms < start_ms) return '0;
        return now_ms - start_ms;
    endfunction

    function automatic t_readout apply_press_or_query(input logic op,
                                                      input logic [TIME_W-1:0] now_ms);
        t_readout             r;
        longint unsigned      el;
        if (op == OP_PRESS) begin
            case (watch_mode)
                MODE_READY: begin
                    start_ms   = now_ms;
                    held_ms    = '0;
                    watch_mode = MODE_RUNNING;
                end
                MODE_RUNNING: begin
                    held_ms    = elapsed_at(now_ms);
                    watch_mode = MODE_STOPPED;
                end
                default: begin
                    clear_watch();
                end
            endcase
        end
        r.elapsed   = elapsed_at(now_ms);
        el          = 64'(r.elapsed);
        r.mode      = watch_mode;
        r.long_form = (el >= HOUR_MS);
        r.hours     = r.long_form ? HOURS_W'(el / HOUR_MS) : '0;
        r.minutes   = MIN_W'((el / MINUTE_MS) % 64'd60);
        r.seconds   = SEC_W'((el / SECOND_MS) % 64'd60);
        r.tenths    = r.long_form ? '0 : TENTHS_W'((el / TENTH_MS) % 64'd10);
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_readout want;
        if (!i_rst_n) begin
            clear_watch();
            readout_q.delete();
        end else begin
            if (i_s_tvalid && i_s_tready) begin
                readout_q.push_back(apply_press_or_query(i_s_tuser,
                                                         i_s_tdata[TIME_W-1:0]));
            end
            if (i_m_tvalid && i_m_tready) begin
                if (readout_q.size() == 0) begin
                    report_mismatch("result with nothing expected", i_m_tdata[63:0], '0);
                end else begin
                    want = readout_q.pop_front();
                    if (i_m_tdata[1:0] !== want.mode)
                        report_mismatch("watch_mode", 64'(i_m_tdata[1:0]), 64'(want.mode));
                    if (i_m_tdata[41:2] !== want.elapsed)
                        report_mismatch("elapsed_ms", 64'(i_m_tdata[41:2]),
                                        64'(want.elapsed));
                    if (i_m_tuser !== want.long_form)
                        report_mismatch("long_form", 64'(i_m_tuser), 64'(want.long_form));
                    if (i_m_tdata[60:42] !== want.hours)
                        report_mismatch("hours", 64'(i_m_tdata[60:42]), 64'(want.hours));
                    if (i_m_tdata[66:61] !== want.minutes)
                        report_mismatch("minutes", 64'(i_m_tdata[66:61]),
                                        64'(want.minutes));
                    if (i_m_tdata[72:67] !== want.seconds)
                        report_mismatch("seconds", 64'(i_m_tdata[72:67]),
                                        64'(want.seconds));
                    if (i_m_tdata[76:73] !== want.tenths)
                        report_mismatch("tenths", 64'(i_m_tdata[76:73]), 64'(want.tenths));
                    if (i_m_tdata[OUT_TDATA_W-1:OUT_FIELD_W] !== '0)
                        report_mismatch("padding",
                                        64'(i_m_tdata[OUT_TDATA_W-1:OUT_FIELD_W]), '0);
                    if (want.long_form) long_seen++;
                    checked++;
                end
            end
        end
        o_pending <= readout_q.size();
    end

endmodule

// ===== test/tb_stopwatch_with_time_readout.sv =====
// testbench top for the stopwatch with time readout: clock, reset, stimulus, verdict
// depends on swt_pkg, stopwatch_with_time_readout and swt_readout_checker

module tb_stopwatch_with_time_readout;

    timeunit 1ns;
    timeprecision 1ps;

    import swt_pkg::*;

    localparam logic [TIME_W-1:0] TIME_MAX  = '1;
    localparam int                HOLD_LEN  = 80;   // long receiver stall, in cycles
    localparam int                DRAIN_GAP = 20;   // idle clocks after the last drain

    logic                   i_clk      = 1'b0;
    logic                   i_rst_n    = 1'b0;
    logic                   i_s_tvalid = 1'b0;
    logic                   o_s_tready;
    logic [IN_TDATA_W-1:0]  i_s_tdata  = '0;    // [39:0] now_ms
    logic                   i_s_tuser  = 1'b0;  // [0] op
    logic                   o_m_tvalid;
    logic                   i_m_tready = 1'b0;
    // [1:0] watch_mode, [41:2] elapsed_ms, [60:42] hours, [66:61] minutes,
    // [72:67] seconds, [76:73] tenths, [79:77] zero
    logic [OUT_TDATA_W-1:0] o_m_tdata;
    logic                   o_m_tuser;          // [0] long_form

    int fail_count;
    int pending;
    int checked;
    int long_seen;

    // idling controls set by the sender and read by the receiver
    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    int rx_hold_req = 0;   // number of long stalls requested so far

    int                n_press = 0;
    int                n_query = 0;
    logic [TIME_W-1:0] wall_ms = '0;   // monotonic time base for the random part

    always #5 i_clk = ~i_clk;

    stopwatch_with_time_readout dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    swt_readout_checker checker_i (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (i_s_tvalid),
        .i_s_tready   (o_s_tready),
        .i_s_tdata    (i_s_tdata),
        .i_s_tuser    (i_s_tuser),
        .i_m_tvalid   (o_m_tvalid),
        .i_m_tready   (i_m_tready),
        .i_m_tdata    (o_m_tdata),
        .i_m_tuser    (o_m_tuser),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked),
        .o_long_seen  (long_seen)
    );

    // receiver: random back pressure, plus a long stall whenever one is requested
    initial begin
        int hold_left;
        int hold_served;
        hold_left   = 0;
        hold_served = 0;
        forever begin
            @(posedge i_clk);
            if (rx_hold_req != hold_served) begin
                hold_served = rx_hold_req;
                hold_left   = HOLD_LEN;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_m_tready <= 1'b0;
            end else begin
                i_m_tready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    // offer one transfer, idling first at the current rate, and wait for acceptance
    task automatic send_item(input logic op, input logic [TIME_W-1:0] now_ms);
        while (tx_idle_pct > 0 && $urandom_range(99) < tx_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= now_ms;
        i_s_tuser  <= op;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        if (op == OP_PRESS) n_press++;
        else n_query++;
    endtask

    // sender goes quiet until every predicted readout has come back
    task automatic wait_all_results();
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    // mostly a clock moving forward by mixed step sizes, with some random times
    // thrown in so that the clock seems to run backwards now and then
    task automatic send_random(input int count);
        int                pick;
        logic [TIME_W-1:0] now_ms;
        logic [TIME_W-1:0] delta;
        logic              op;
        for (int k = 0; k < count; k++) begin
            pick = $urandom_range(99);
            if (pick < 8) begin
                now_ms = TIME_W'({$urandom, $urandom});
            end else begin
                if (pick < 60) delta = TIME_W'($urandom_range(1500));
                else if (pick < 80) delta = TIME_W'($urandom_range(120000));
                else if (pick < 95) delta = TIME_W'($urandom_range(12 * 3600000));
                else delta = TIME_W'({$urandom, $urandom}) >> $urandom_range(TIME_W - 1);
                wall_ms = wall_ms + delta;
                now_ms  = wall_ms;
            end
            op = ($urandom_range(3) == 0) ? OP_PRESS : OP_QUERY;
            send_item(op, now_ms);
            // long receiver stall in the middle of each stressed phase
            if (k == count / 2 && rx_idle_pct != 0) rx_hold_req++;
        end
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // phase one: sender idles 36%, receiver 63%
        tx_idle_pct = 36;
        rx_idle_pct = 63;

        // directed: readout boundaries, full range, backwards clock, every transition
        send_item(OP_QUERY, '0);                  // ready, nothing held
        send_item(OP_QUERY, TIME_MAX);
        send_item(OP_PRESS, '0);                  // ready -> running from zero
        send_item(OP_QUERY, 40'd99);              // below one tenth
        send_item(OP_QUERY, 40'd100);
        send_item(OP_QUERY, 40'd999);
        send_item(OP_QUERY, 40'd59999);           // minute boundary
        send_item(OP_QUERY, 40'd60000);
        send_item(OP_QUERY, 40'd3599999);         // last short-form value
        send_item(OP_QUERY, 40'd3600000);         // first long-form value
        send_item(OP_QUERY, TIME_MAX);            // largest elapsed, largest hours
        send_item(OP_PRESS, TIME_MAX);            // running -> stopped, max held
        send_item(OP_QUERY, '0);                  // held value ignores the clock
        send_item(OP_PRESS, 40'd7);               // stopped -> ready, all cleared
        send_item(OP_PRESS, 40'd5000);            // start at 5 s
        send_item(OP_QUERY, 40'd4999);            // clock ran backwards: zero
        send_item(OP_PRESS, 40'd4000);            // stop while backwards: holds zero
        send_item(OP_QUERY, 40'd9000);
        send_item(OP_PRESS, 40'd1);               // back to ready
        send_item(OP_PRESS, TIME_MAX - 40'd1);    // start at the top of the range
        send_item(OP_QUERY, TIME_MAX);
        send_item(OP_PRESS, TIME_MAX);            // hold one millisecond
        send_item(OP_PRESS, '0);                  // back to ready

        send_random(600);
        wait_all_results();

        // phase two: the rates swapped
        tx_idle_pct = 63;
        rx_idle_pct = 36;
        send_random(600);
        wait_all_results();

        // phase three: full rate on both sides
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        send_random(625);

        wait_all_results();
        repeat (DRAIN_GAP) @(posedge i_clk);

        $display("stimulus: %0d presses and %0d queries over three idling phases, %s",
                 n_press, n_query, "with long output stalls and full drains");
        $display("readouts checked: %0d, of them %0d in long form", checked, long_seen);
        if (fail_count == 0 && pending == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    // watchdog, far beyond the slowest legal run
    initial begin
        #5_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/swt_pkg.sv
rtl/swt_split.sv
rtl/stopwatch_with_time_readout.sv
test/swt_readout_checker.sv
test/tb_stopwatch_with_time_readout.sv
